### sv/sdcu_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the steering and drive command unit
package sdcu_pkg;

    // item kinds
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_ENC  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_COMMAND_ID       = 3'd0;
    localparam logic [2:0] REG_STEER_LIMIT      = 3'd1;
    localparam logic [2:0] REG_SPEED_MAX        = 3'd2;
    localparam logic [2:0] REG_SLEW_STEP        = 3'd3;
    localparam logic [2:0] REG_WATCHDOG_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_FEEDBACK_PERIOD  = 3'd5;
    localparam logic [2:0] REG_SERVO_LOW        = 3'd6;
    localparam logic [2:0] REG_SERVO_HIGH       = 3'd7;

    // register reset values
    localparam logic [10:0] RST_COMMAND_ID       = 11'd512;
    localparam logic [10:0] RST_STEER_LIMIT      = 11'd2000;
    localparam logic [15:0] RST_SPEED_MAX        = 16'd1000;
    localparam logic [11:0] RST_SLEW_STEP        = 12'd15;
    localparam logic [15:0] RST_WATCHDOG_TIMEOUT = 16'd100;
    localparam logic [15:0] RST_FEEDBACK_PERIOD  = 16'd20;
    localparam logic [15:0] RST_SERVO_LOW        = 16'd690;
    localparam logic [15:0] RST_SERVO_HIGH       = 16'd840;

    // servo mapping: bits handled per cycle and step counts
    localparam int MAP_DIGIT = 2;
    localparam int MUL_BITS  = 12;
    localparam int DIV_BITS  = 16;
    localparam int MUL_STEPS = MUL_BITS / MAP_DIGIT;
    localparam int DIV_STEPS = DIV_BITS / MAP_DIGIT;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        MAP_IDLE,
        MAP_MUL,
        MAP_DIV,
        MAP_FIX,
        MAP_DONE
    } t_map_state;

    typedef struct packed {
        logic start;
        logic take;
    } t_map_ctl;

endpackage

### sv/sdcu_item_if.sv
`timescale 1ns / 1ps
// input item channel of the steering and drive command unit
interface sdcu_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [10:0] frame_id;
    logic [7:0]  payload_b0;
    logic [7:0]  payload_b1;
    logic [7:0]  payload_b2;
    logic [7:0]  payload_b3;
    logic [15:0] encoder_sample;

    modport source (
        output valid, kind, frame_id, payload_b0, payload_b1, payload_b2, payload_b3,
               encoder_sample,
        input  ready
    );

    modport sink (
        input  valid, kind, frame_id, payload_b0, payload_b1, payload_b2, payload_b3,
               encoder_sample,
        output ready
    );
endinterface

### sv/sdcu_result_if.sv
`timescale 1ns / 1ps
// result channel of the steering and drive command unit
interface sdcu_result_if;
    logic               valid;
    logic               ready;
    logic [15:0]        servo_compare;
    logic [15:0]        motor_duty;
    logic signed [11:0] steer_position;
    logic               watchdog_tripped;
    logic               feedback_valid;
    logic [31:0]        feedback_count;

    modport source (
        output valid, servo_compare, motor_duty, steer_position, watchdog_tripped,
               feedback_valid, feedback_count,
        input  ready
    );

    modport sink (
        input  valid, servo_compare, motor_duty, steer_position, watchdog_tripped,
               feedback_valid, feedback_count,
        output ready
    );
endinterface

### sv/steer_drive_command_unit.sv
`timescale 1ns / 1ps
// steering and drive command unit top level
//
// input channel i_item carries command frames, millisecond ticks and encoder
// samples; each accepted transaction gives exactly one transaction on o_result
// with the servo compare value, motor duty, steering position, watchdog flag,
// feedback flag and extended encoder count
// registers are written over the apb port at byte address 4*index
// the state update happens at the accepting edge; the servo compare value then
// comes from a setup step, a serial shift-add multiply and a restoring divide,
// two bits per cycle, and a sign fix step
// a new item is taken only once the previous result has left the mapping unit
// reset loads the register defaults and clears the unit state and the valid and
// control flags; the result data and mapping datapath registers are not reset
// a result waiting on a stalled receiver stays in the output register while
// the next item is accepted; that item's result waits in the mapping unit
module steer_drive_command_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sdcu_item_if.sink             i_item,
    sdcu_result_if.source         o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // configuration
    logic [10:0] r_command_id;
    logic [10:0] r_steer_limit;
    logic [15:0] r_speed_max;
    logic [11:0] r_slew_step;
    logic [15:0] r_watchdog_timeout;
    logic [15:0] r_feedback_period;
    logic [15:0] r_servo_low;
    logic [15:0] r_servo_high;

    // unit state
    logic signed [11:0] r_steer_target, n_steer_target;
    logic signed [11:0] r_steer_actual, n_steer_actual;
    logic [15:0]        r_duty,         n_duty;
    logic               r_cmd_seen,     n_cmd_seen;
    logic [15:0]        r_ms_cmd,       n_ms_cmd;
    logic [15:0]        r_ms_fb,        n_ms_fb;
    logic [15:0]        r_enc_prev,     n_enc_prev;
    logic [15:0]        r_enc_wraps,    n_enc_wraps;

    // control
    logic r_busy,    n_busy;
    logic r_start,   n_start;
    logic r_fb_pend, n_fb_pend;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [15:0]        r_out_servo;
    logic [15:0]        r_out_duty;
    logic signed [11:0] r_out_pos;
    logic               r_out_trip;
    logic               r_out_fb;
    logic [31:0]        r_out_count;

    logic               w_accept;
    logic               w_cfg_write;
    logic               w_take;
    logic               w_map_done;
    logic [15:0]        w_map_compare;
    sdcu_pkg::t_map_ctl w_map_ctl;

    // command decode
    logic signed [15:0] w_raw;
    logic signed [19:0] w_raw20;
    logic signed [19:0] w_raw10;
    logic signed [19:0] w_lim20;
    logic signed [19:0] w_target20;
    logic [15:0]        w_speed;
    logic [15:0]        w_duty_clamped;

    // tick
    logic [15:0]        w_ms_cmd_inc;
    logic               w_trip_next;
    logic signed [12:0] w_delta;
    logic signed [12:0] w_step;
    logic signed [12:0] w_delta_cl;
    logic signed [12:0] w_slewed;
    logic [15:0]        w_ms_fb_inc;
    logic               w_fb_due;

    assign w_accept    = i_item.valid && i_item.ready;
    assign w_cfg_write = psel && penable && pwrite;
    assign pready      = 1'b1;

    assign w_raw      = {i_item.payload_b1, i_item.payload_b0};
    assign w_raw20    = {{4{w_raw[15]}}, w_raw};
    assign w_raw10    = (w_raw20 <<< 3) + (w_raw20 <<< 1);
    assign w_lim20    = {9'd0, r_steer_limit};
    assign w_target20 = (w_raw10 > w_lim20) ? w_lim20 :
                        ((w_raw10 < -w_lim20) ? -w_lim20 : w_raw10);
    assign w_speed        = {i_item.payload_b3, i_item.payload_b2};
    assign w_duty_clamped = (w_speed > r_speed_max) ? r_speed_max : w_speed;

    assign w_ms_cmd_inc = (r_ms_cmd != 16'hFFFF) ? (r_ms_cmd + 16'd1) : r_ms_cmd;
    assign w_trip_next  = r_cmd_seen && (w_ms_cmd_inc > r_watchdog_timeout);
    assign w_delta      = {r_steer_target[11], r_steer_target}
                        - {r_steer_actual[11], r_steer_actual};
    assign w_step       = {1'b0, r_slew_step};
    assign w_delta_cl   = (w_delta > w_step) ? w_step :
                          ((w_delta < -w_step) ? -w_step : w_delta);
    assign w_slewed     = {r_steer_actual[11], r_steer_actual} + w_delta_cl;
    assign w_ms_fb_inc  = r_ms_fb + 16'd1;
    assign w_fb_due     = (w_ms_fb_inc >= r_feedback_period);

    assign w_take = w_map_done && (!r_out_valid || o_result.ready);

    always_comb begin
        n_steer_target = r_steer_target;
        n_steer_actual = r_steer_actual;
        n_duty         = r_duty;
        n_cmd_seen     = r_cmd_seen;
        n_ms_cmd       = r_ms_cmd;
        n_ms_fb        = r_ms_fb;
        n_enc_prev     = r_enc_prev;
        n_enc_wraps    = r_enc_wraps;
        n_fb_pend      = r_fb_pend;
        if (w_accept) begin
            n_fb_pend = 1'b0;
            case (i_item.kind)
                sdcu_pkg::KIND_CMD: begin
                    if (i_item.frame_id == r_command_id) begin
                        n_steer_target = w_target20[11:0];
                        n_duty         = w_duty_clamped;
                        n_ms_cmd       = '0;
                        n_cmd_seen     = 1'b1;
                    end
                end
                sdcu_pkg::KIND_TICK: begin
                    n_ms_cmd       = w_ms_cmd_inc;
                    n_steer_actual = w_slewed[11:0];
                    if (w_trip_next) begin
                        n_duty = '0;
                    end
                    if (w_fb_due) begin
                        n_ms_fb   = '0;
                        n_fb_pend = 1'b1;
                    end else begin
                        n_ms_fb = w_ms_fb_inc;
                    end
                end
                sdcu_pkg::KIND_ENC: begin
                    if (i_item.encoder_sample < r_enc_prev) begin
                        n_enc_wraps = r_enc_wraps + 16'd1;
                    end
                    n_enc_prev = i_item.encoder_sample;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_start = w_accept;
        n_busy  = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (w_take) begin
            n_busy = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command_id       <= sdcu_pkg::RST_COMMAND_ID;
            r_steer_limit      <= sdcu_pkg::RST_STEER_LIMIT;
            r_speed_max        <= sdcu_pkg::RST_SPEED_MAX;
            r_slew_step        <= sdcu_pkg::RST_SLEW_STEP;
            r_watchdog_timeout <= sdcu_pkg::RST_WATCHDOG_TIMEOUT;
            r_feedback_period  <= sdcu_pkg::RST_FEEDBACK_PERIOD;
            r_servo_low        <= sdcu_pkg::RST_SERVO_LOW;
            r_servo_high       <= sdcu_pkg::RST_SERVO_HIGH;
        end else if (w_cfg_write) begin
            unique case (paddr[4:2])
                sdcu_pkg::REG_COMMAND_ID:       r_command_id       <= pwdata[10:0];
                sdcu_pkg::REG_STEER_LIMIT:      r_steer_limit      <= pwdata[10:0];
                sdcu_pkg::REG_SPEED_MAX:        r_speed_max        <= pwdata[15:0];
                sdcu_pkg::REG_SLEW_STEP:        r_slew_step        <= pwdata[11:0];
                sdcu_pkg::REG_WATCHDOG_TIMEOUT: r_watchdog_timeout <= pwdata[15:0];
                sdcu_pkg::REG_FEEDBACK_PERIOD:  r_feedback_period  <= pwdata[15:0];
                sdcu_pkg::REG_SERVO_LOW:        r_servo_low        <= pwdata[15:0];
                sdcu_pkg::REG_SERVO_HIGH:       r_servo_high       <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            sdcu_pkg::REG_COMMAND_ID:       prdata = {21'd0, r_command_id};
            sdcu_pkg::REG_STEER_LIMIT:      prdata = {21'd0, r_steer_limit};
            sdcu_pkg::REG_SPEED_MAX:        prdata = {16'd0, r_speed_max};
            sdcu_pkg::REG_SLEW_STEP:        prdata = {20'd0, r_slew_step};
            sdcu_pkg::REG_WATCHDOG_TIMEOUT: prdata = {16'd0, r_watchdog_timeout};
            sdcu_pkg::REG_FEEDBACK_PERIOD:  prdata = {16'd0, r_feedback_period};
            sdcu_pkg::REG_SERVO_LOW:        prdata = {16'd0, r_servo_low};
            sdcu_pkg::REG_SERVO_HIGH:       prdata = {16'd0, r_servo_high};
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steer_target <= '0;
            r_steer_actual <= '0;
            r_duty         <= '0;
            r_cmd_seen     <= 1'b0;
            r_ms_cmd       <= '0;
            r_ms_fb        <= '0;
            r_enc_prev     <= '0;
            r_enc_wraps    <= '0;
            r_fb_pend      <= 1'b0;
            r_busy         <= 1'b0;
            r_start        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_steer_target <= n_steer_target;
            r_steer_actual <= n_steer_actual;
            r_duty         <= n_duty;
            r_cmd_seen     <= n_cmd_seen;
            r_ms_cmd       <= n_ms_cmd;
            r_ms_fb        <= n_ms_fb;
            r_enc_prev     <= n_enc_prev;
            r_enc_wraps    <= n_enc_wraps;
            r_fb_pend      <= n_fb_pend;
            r_busy         <= n_busy;
            r_start        <= n_start;
            r_out_valid    <= n_out_valid;
        end
    end

    // result snapshot, state is frozen until the transaction moves out
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_servo <= w_map_compare;
            r_out_duty  <= r_duty;
            r_out_pos   <= r_steer_actual;
            r_out_trip  <= r_cmd_seen && (r_ms_cmd > r_watchdog_timeout);
            r_out_fb    <= r_fb_pend;
            r_out_count <= {r_enc_wraps, r_enc_prev};
        end
    end

    assign w_map_ctl.start = r_start;
    assign w_map_ctl.take  = w_take;

    sdcu_servo_map u_servo_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_map_ctl),
        .i_position (r_steer_actual),
        .i_limit    (r_steer_limit),
        .i_low      (r_servo_low),
        .i_high     (r_servo_high),
        .o_done     (w_map_done),
        .o_compare  (w_map_compare)
    );

    assign i_item.ready              = !r_busy;
    assign o_result.valid            = r_out_valid;
    assign o_result.servo_compare    = r_out_servo;
    assign o_result.motor_duty       = r_out_duty;
    assign o_result.steer_position   = r_out_pos;
    assign o_result.watchdog_tripped = r_out_trip;
    assign o_result.feedback_valid   = r_out_fb;
    assign o_result.feedback_count   = r_out_count;

    a_zero_slew_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.kind == sdcu_pkg::KIND_TICK) && (r_slew_step == 12'd0))
        |=> $stable(r_steer_actual))
        else $error("steering moved with zero slew step");

    a_ms_cmd_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ms_cmd == 16'hFFFF) |=> ((r_ms_cmd == 16'hFFFF) || (r_ms_cmd == 16'd0)))
        else $error("command age counter wrapped");

    a_done_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_map_done |-> r_busy)
        else $error("servo mapping finished with no transaction in flight");

    a_wrap_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_enc_wraps == $past(r_enc_wraps))
               || (r_enc_wraps == ($past(r_enc_wraps) + 16'd1))))
        else $error("encoder wrap count jumped");

endmodule

### sv/sdcu_servo_map.sv
`timescale 1ns / 1ps
// serial servo mapping: shift-add multiply and restoring divide, two bits per cycle
module sdcu_servo_map (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sdcu_pkg::t_map_ctl  i_ctl,
    input  logic signed [11:0]  i_position,
    input  logic [10:0]         i_limit,
    input  logic [15:0]         i_low,
    input  logic [15:0]         i_high,
    output logic                o_done,
    output logic [15:0]         o_compare
);

    sdcu_pkg::t_map_state r_state, n_state;
    logic [sdcu_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic [15:0] r_md,  n_md;
    logic        r_neg, n_neg;
    logic [11:0] r_den, n_den;
    logic [15:0] r_hi,  n_hi;
    logic [11:0] r_lo,  n_lo;
    logic [11:0] r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic [15:0] r_result, n_result;

    logic signed [12:0] w_lim;
    logic signed [12:0] w_pos;
    logic signed [12:0] w_clamped;
    logic signed [12:0] w_offset;
    logic [11:0]        w_a;
    logic signed [16:0] w_diff;
    logic [15:0]        w_mag;

    logic [15:0] w_mul_hi;
    logic [11:0] w_mul_lo;
    logic [16:0] w_mul_sum;
    logic [11:0] w_div_rem;
    logic [15:0] w_div_quo;
    logic [12:0] w_div_t;
    logic        w_div_bit;

    // operand setup
    assign w_lim     = {2'b00, i_limit};
    assign w_pos     = {i_position[11], i_position};
    assign w_clamped = (w_pos > w_lim) ? w_lim : ((w_pos < -w_lim) ? -w_lim : w_pos);
    assign w_offset  = w_clamped + w_lim;
    assign w_a       = w_offset[11:0];
    assign w_diff    = $signed({1'b0, i_high}) - $signed({1'b0, i_low});
    assign w_mag     = w_diff[16] ? 16'(-w_diff) : w_diff[15:0];

    // multiply digit
    always_comb begin
        w_mul_hi  = r_hi;
        w_mul_lo  = r_lo;
        w_mul_sum = '0;
        for (int k = 0; k < sdcu_pkg::MAP_DIGIT; k++) begin
            w_mul_sum = {1'b0, w_mul_hi} + (w_mul_lo[0] ? {1'b0, r_md} : 17'd0);
            w_mul_lo  = {w_mul_sum[0], w_mul_lo[11:1]};
            w_mul_hi  = w_mul_sum[16:1];
        end
    end

    // divide digit
    always_comb begin
        w_div_rem = r_rem;
        w_div_quo = r_quo;
        w_div_t   = '0;
        w_div_bit = 1'b0;
        for (int k = 0; k < sdcu_pkg::MAP_DIGIT; k++) begin
            w_div_t = {w_div_rem, w_div_quo[15]};
            if (w_div_t >= {1'b0, r_den}) begin
                w_div_rem = 12'(w_div_t - {1'b0, r_den});
                w_div_bit = 1'b1;
            end else begin
                w_div_rem = w_div_t[11:0];
                w_div_bit = 1'b0;
            end
            w_div_quo = {w_div_quo[14:0], w_div_bit};
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_md     = r_md;
        n_neg    = r_neg;
        n_den    = r_den;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_result = r_result;
        unique case (r_state)
            sdcu_pkg::MAP_IDLE: begin
                if (i_ctl.start) begin
                    n_md  = w_mag;
                    n_neg = w_diff[16];
                    n_den = {i_limit, 1'b0};
                    n_hi  = '0;
                    n_lo  = w_a;
                    n_cnt = '0;
                    if (i_limit == 11'd0) begin
                        n_result = i_low;
                        n_state  = sdcu_pkg::MAP_DONE;
                    end else begin
                        n_state = sdcu_pkg::MAP_MUL;
                    end
                end
            end
            sdcu_pkg::MAP_MUL: begin
                n_hi  = w_mul_hi;
                n_lo  = w_mul_lo;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == sdcu_pkg::MUL_LAST) begin
                    // quotient fits 16 bits, so the top product bits seed the remainder
                    n_rem   = w_mul_hi[15:4];
                    n_quo   = {w_mul_hi[3:0], w_mul_lo};
                    n_cnt   = '0;
                    n_state = sdcu_pkg::MAP_DIV;
                end
            end
            sdcu_pkg::MAP_DIV: begin
                n_rem = w_div_rem;
                n_quo = w_div_quo;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == sdcu_pkg::DIV_LAST) begin
                    n_state = sdcu_pkg::MAP_FIX;
                end
            end
            sdcu_pkg::MAP_FIX: begin
                // floor of a negative quotient
                if (r_neg) begin
                    n_result = i_low - r_quo - {15'd0, (r_rem != 12'd0)};
                end else begin
                    n_result = i_low + r_quo;
                end
                n_state = sdcu_pkg::MAP_DONE;
            end
            sdcu_pkg::MAP_DONE: begin
                if (i_ctl.take) begin
                    n_state = sdcu_pkg::MAP_IDLE;
                end
            end
            default: begin
                n_state = sdcu_pkg::MAP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdcu_pkg::MAP_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_md     <= n_md;
        r_neg    <= n_neg;
        r_den    <= n_den;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_result <= n_result;
    end

    assign o_done    = (r_state == sdcu_pkg::MAP_DONE);
    assign o_compare = r_result;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdcu_pkg::MAP_DIV) |-> (r_rem < r_den))
        else $error("division remainder not below divisor");

    a_quo_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdcu_pkg::MAP_FIX) |-> (r_quo <= r_md))
        else $error("servo quotient exceeds calibration span");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_state == sdcu_pkg::MAP_IDLE))
        else $error("mapping started while busy");

endmodule
